// ===== rtl/sachm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set-associative cache hit model - shared package
// Address width, configuration register indexes and the control word that
// the sequencer hands to the replacement policy unit.
// ----------------------------------------------------------------------------
package sachm_pkg;

  localparam int ADDR_W     = 64;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_USE_TREE_PLRU  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALLOCATE = 1'b1;

  // Control word for one set update
  typedef struct packed {
    logic tree_mode;  // tree pseudo-LRU instead of recency list
    logic hit;        // lookup hit: refresh recency of the hit way
    logic alloc;      // miss that allocates a way
  } sachm_upd_t;

endpackage

// ===== rtl/sachm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set-associative cache hit model - simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module sachm_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/sachm_policy.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set-associative cache hit model - replacement policy unit
// Computes the new per-set state row (valid bits, fill count, recency list,
// tree bits) and the victim way for one hit or allocating miss.
// ----------------------------------------------------------------------------
module sachm_policy #(
  parameter  int WAYS   = 4,
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1,
  localparam int CNT_W  = $clog2(WAYS + 1),
  localparam int TREE_N = (WAYS > 1) ? WAYS - 1 : 1,
  localparam int ROW_W  = WAYS + CNT_W + WAYS * WAY_W + TREE_N
) (
  input  sachm_pkg::sachm_upd_t ctl,
  input  logic [ROW_W-1:0]      row_in,
  input  logic [WAY_W-1:0]      hit_way,
  input  logic [WAY_W-1:0]      hit_rank,
  output logic [ROW_W-1:0]      row_out,
  output logic [WAY_W-1:0]      victim
);
  import sachm_pkg::*;

  localparam int LEVELS = $clog2(WAYS + 1) - 1;
  localparam int NODE_W = (TREE_N > 1) ? $clog2(TREE_N) : 1;
  localparam int F_LO   = WAYS;
  localparam int L_LO   = WAYS + CNT_W;
  localparam int T_LO   = L_LO + WAYS * WAY_W;

  logic [WAYS-1:0]   valid, valid_n;
  logic [CNT_W-1:0]  fill, fill_n;
  logic [WAY_W-1:0]  lru [WAYS];
  logic [WAY_W-1:0]  lru_n [WAYS];
  logic [TREE_N-1:0] tree, tree_n;
  logic              full;

  // Unpack the row
  assign valid = row_in[WAYS-1:0];
  assign fill  = row_in[L_LO-1:F_LO];
  assign tree  = row_in[ROW_W-1:T_LO];
  assign full  = (fill >= CNT_W'(WAYS));

  for (genvar i = 0; i < WAYS; i++) begin : g_unpack
    assign lru[i] = row_in[L_LO + i*WAY_W +: WAY_W];
    assign row_out[L_LO + i*WAY_W +: WAY_W] = lru_n[i];
  end

  assign row_out[WAYS-1:0]      = valid_n;
  assign row_out[L_LO-1:F_LO]   = fill_n;
  assign row_out[ROW_W-1:T_LO]  = tree_n;

  // Tree walk or recency shift, then mark the allocated way
  always_comb begin
    logic [NODE_W:0]  node;
    logic [WAY_W-1:0] use_way;
    logic [WAY_W-1:0] lim;
    logic             do_shift;
    logic             b;
    valid_n  = valid;
    fill_n   = fill;
    tree_n   = tree;
    for (int i = 0; i < WAYS; i++) begin
      lru_n[i] = lru[i];
    end
    node     = '0;
    use_way  = '0;
    lim      = '0;
    do_shift = 1'b0;
    b        = 1'b0;

    if (ctl.hit) begin
      use_way = hit_way;
      lim     = hit_rank;
      if (ctl.tree_mode) begin
        // Point every node on the path away from the used way
        for (int j = LEVELS - 1; j >= 0; j--) begin
          b = hit_way[j];
          tree_n[node[NODE_W-1:0]] = ~b;
          node = (node << 1) + (NODE_W+1)'(1) + (NODE_W+1)'(b);
        end
      end else begin
        do_shift = 1'b1;
      end
    end else if (ctl.alloc) begin
      if (ctl.tree_mode) begin
        // Follow and flip each node down to the victim leaf
        for (int j = 0; j < LEVELS; j++) begin
          b = tree[node[NODE_W-1:0]];
          tree_n[node[NODE_W-1:0]] = ~b;
          use_way = (use_way << 1) | WAY_W'(b);
          node = (node << 1) + (NODE_W+1)'(1) + (NODE_W+1)'(b);
        end
      end else begin
        // Fill empty ways first, then evict the least recent
        use_way  = full ? lru[WAYS-1] : WAY_W'(fill);
        lim      = full ? WAY_W'(WAYS - 1) : WAY_W'(fill);
        do_shift = 1'b1;
      end
      valid_n[use_way] = 1'b1;
      if (!full) begin
        fill_n = fill + CNT_W'(1);
      end
    end

    // Move ranks above the used way down by one, put the way in front
    if (do_shift) begin
      for (int i = 1; i < WAYS; i++) begin
        if (WAY_W'(i) <= lim) begin
          lru_n[i] = lru[i-1];
        end
      end
      lru_n[0] = use_way;
    end
    victim = use_way;
  end

endmodule

// ===== rtl/set_assoc_cache_hit_model_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set-associative cache hit model - top level
// Tag-only cache lookup with true LRU or tree pseudo-LRU replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with address and is_read while busy is low; the word is taken
//   at that edge. busy stays high until the result is out. The result appears
//   on hit, marked by done for exactly one cycle; the receiver cannot stall.
//   A new word may be started in the same cycle that done is high.
//   Sequence: the set row is read, then the single shared comparator checks
//   the ways one at a time (stopping at the first hit), then on a hit with
//   the recency list it scans the ranks in turn (up to WAYS+1 of them), then
//   the set row is updated, all with busy high. done is registered from the
//   update step and rises in the cycle after it, as busy falls.
//   Configuration: cfg_we writes cfg_data into register cfg_index (0 selects
//   tree pseudo-LRU, 1 enables write allocation); write only while idle.
//   Reset: after rst the set state memory is cleared one set per cycle, all
//   2**SET_BITS sets, with busy high; configuration writes are still taken.
// ----------------------------------------------------------------------------
module set_assoc_cache_hit_model_core #(
  parameter int OFFSET_BITS = 6,
  parameter int SET_BITS    = 7,
  parameter int WAYS        = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [sachm_pkg::ADDR_W-1:0]    address,
  input  logic                            is_read,
  output logic                            done,
  output logic                            hit,
  input  logic                            cfg_we,
  input  logic [sachm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sachm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sachm_pkg::*;

  localparam int NUM_SETS = 1 << SET_BITS;
  localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int TAG_W    = ADDR_W - OFFSET_BITS - SET_BITS;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W    = $clog2(WAYS + 1);
  localparam int TREE_N   = (WAYS > 1) ? WAYS - 1 : 1;
  localparam int ROW_W    = WAYS + CNT_W + WAYS * WAY_W + TREE_N;
  localparam int F_LO     = WAYS;
  localparam int L_LO     = WAYS + CNT_W;

  // Sequencer states
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_TAG    = 3'd3;
  localparam logic [2:0] S_RANK   = 3'd4;
  localparam logic [2:0] S_UPDATE = 3'd5;

  logic [2:0]       state, state_next;
  logic [SET_W-1:0] clr_cnt;
  logic [SET_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q;
  logic             is_read_q;
  logic [WAY_W-1:0] way_cnt;
  logic [CNT_W-1:0] rank_cnt;
  logic [WAY_W-1:0] found_way;
  logic [WAY_W-1:0] hit_rank;
  logic             hit_q;
  logic             use_tree_plru;
  logic             write_allocate;

  logic [SET_W-1:0]       in_set;
  logic [ROW_W-1:0]       meta_row, row_next;
  logic                   meta_we;
  logic [SET_W-1:0]       meta_waddr;
  logic [ROW_W-1:0]       meta_wdata;
  logic [TAG_W-1:0]       tag_rdata;
  logic [SET_W+WAY_W-1:0] tag_raddr;
  logic                   tag_we;
  logic [WAYS-1:0]        row_valid;
  logic [CNT_W-1:0]       row_fill;
  logic [WAY_W-1:0]       rank_entry;
  logic [TAG_W-1:0]       cmp_a, cmp_b;
  logic                   cmp_eq;
  logic                   alloc;
  logic [WAY_W-1:0]       victim;
  sachm_upd_t             upd;

  assign in_set = SET_W'(address >> OFFSET_BITS) & SET_W'(NUM_SETS - 1);
  assign alloc  = is_read_q | write_allocate;
  assign busy   = (state != S_IDLE);

  // Fields of the set row
  assign row_valid  = meta_row[WAYS-1:0];
  assign row_fill   = meta_row[L_LO-1:F_LO];
  assign rank_entry = meta_row[L_LO + int'(rank_cnt[WAY_W-1:0]) * WAY_W +: WAY_W];

  // Shared comparator: tag against way in tag scan, way number against rank
  assign cmp_a  = (state == S_RANK) ? TAG_W'(rank_entry) : tag_rdata;
  assign cmp_b  = (state == S_RANK) ? TAG_W'(found_way) : tag_q;
  assign cmp_eq = (cmp_a == cmp_b);

  // Memories
  assign meta_we    = (state == S_CLEAR) || ((state == S_UPDATE) && (hit_q || alloc));
  assign meta_waddr = (state == S_CLEAR) ? clr_cnt : set_q;
  assign meta_wdata = (state == S_CLEAR) ? '0 : row_next;
  assign tag_we     = (state == S_UPDATE) && !hit_q && alloc;
  assign tag_raddr  = (state == S_TAG) ? {set_q, way_cnt + WAY_W'(1)} : {set_q, WAY_W'(0)};

  sachm_ram #(.DATA_W(ROW_W), .ADDR_W(SET_W)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (state == S_READ),
    .raddr (set_q),
    .rdata (meta_row)
  );

  sachm_ram #(.DATA_W(TAG_W), .ADDR_W(SET_W + WAY_W)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr ({set_q, victim}),
    .wdata (tag_q),
    .re    (1'b1),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  // Replacement policy
  assign upd.tree_mode = use_tree_plru;
  assign upd.hit       = hit_q;
  assign upd.alloc     = alloc;

  sachm_policy #(.WAYS(WAYS)) u_policy (
    .ctl      (upd),
    .row_in   (meta_row),
    .hit_way  (found_way),
    .hit_rank (hit_rank),
    .row_out  (row_next),
    .victim   (victim)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_cnt == SET_W'(NUM_SETS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_next = S_READ;
      end
      S_READ: begin
        state_next = S_TAG;
      end
      S_TAG: begin
        if (cmp_eq && row_valid[way_cnt]) begin
          state_next = use_tree_plru ? S_UPDATE : S_RANK;
        end else if (way_cnt == WAY_W'(WAYS - 1)) begin
          state_next = S_UPDATE;
        end
      end
      S_RANK: begin
        if ((rank_cnt == row_fill) || cmp_eq) state_next = S_UPDATE;
      end
      S_UPDATE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_UPDATE);
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + SET_W'(1);
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      use_tree_plru  <= 1'b0;
      write_allocate <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_USE_TREE_PLRU:  use_tree_plru  <= cfg_data[0];
        CFG_WRITE_ALLOCATE: write_allocate <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Datapath registers: latch the word, scan ways, scan ranks, drive result
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && start) begin
      set_q     <= in_set;
      tag_q     <= TAG_W'(address >> (OFFSET_BITS + SET_BITS));
      is_read_q <= is_read;
    end
    if (state == S_READ) begin
      way_cnt <= '0;
      hit_q   <= 1'b0;
    end
    if (state == S_TAG) begin
      way_cnt  <= way_cnt + WAY_W'(1);
      rank_cnt <= '0;
      if (cmp_eq && row_valid[way_cnt]) begin
        hit_q     <= 1'b1;
        found_way <= way_cnt;
      end
    end
    if (state == S_RANK) begin
      rank_cnt <= rank_cnt + CNT_W'(1);
      if ((rank_cnt == row_fill) || cmp_eq) begin
        hit_rank <= (rank_cnt >= CNT_W'(WAYS)) ? WAY_W'(WAYS - 1) : rank_cnt[WAY_W-1:0];
      end
    end
    if (state == S_UPDATE) begin
      hit <= hit_q;
    end
  end

endmodule

// ===== rtl/sachm_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set-associative cache hit model - port monitor
// Checks the start/busy/done sequencing seen on the top level ports.
// ----------------------------------------------------------------------------
module sachm_monitor (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // An accepted word makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // The result strobe comes as the block goes idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(busy)))
    else $error("done without busy falling");

  // One result per word: the strobe lasts a single cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

endmodule

bind set_assoc_cache_hit_model_core sachm_monitor u_sachm_monitor (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

// ===== dv/set_assoc_cache_hit_model_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set-associative cache hit model - block test
// Drives cache accesses through the start/busy port and checks every hit flag
// against a tag-level copy of the cache state kept in the test. A short table
// covers reset, address extremes, write allocation, both replacement policies
// and policy switches; random phases then hammer a few hot sets with a small
// pool of tags under every register setting, mixed with fully random words.
// ----------------------------------------------------------------------------
module set_assoc_cache_hit_model_core_test;
  import sachm_pkg::*;

  localparam int OFFSET_BITS = 6;
  localparam int SET_BITS    = 7;
  localparam int WAYS        = 4;
  localparam int NUM_SETS    = 1 << SET_BITS;
  localparam int TAG_W       = ADDR_W - OFFSET_BITS - SET_BITS;
  localparam int TREE_NODES  = (WAYS > 1) ? WAYS - 1 : 1;
  localparam int TREE_LEVELS = $clog2(WAYS + 1) - 1;
  localparam int MAX_LATENCY = 2 * WAYS + 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOT_SETS    = 4;
  localparam int HOT_TAGS    = 6;
  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 100;

  typedef logic [TAG_W-1:0] tag_t;

  typedef enum bit {ROW_ACCESS, ROW_CONFIG} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [ADDR_W-1:0]      addr;
    logic                   rd;
    bit                     known;
    logic                   hit;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
  } stim_row_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic              hit;
  } hit_expect_t;

  // Clock and block ports
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [ADDR_W-1:0]     address = '0;
  logic                  is_read = 1'b0;
  logic                  done;
  logic                  hit;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Cache state mirror
  tag_t line_tag   [NUM_SETS*WAYS];
  bit   line_valid [NUM_SETS*WAYS];
  int   fill_cnt   [NUM_SETS];
  int   recency    [NUM_SETS*WAYS];
  bit   tree_bits  [NUM_SETS*TREE_NODES];
  bit   tree_mode      = 1'b0;
  bit   alloc_on_write = 1'b1;

  hit_expect_t pending_hits[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;

  set_assoc_cache_hit_model_core #(
    .OFFSET_BITS(OFFSET_BITS),
    .SET_BITS   (SET_BITS),
    .WAYS       (WAYS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .address  (address),
    .is_read  (is_read),
    .done     (done),
    .hit      (hit),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Refresh recency of a hit way in the active policy
  function automatic void touch_way(int s, int w);
    int base;
    int node;
    int idx;
    int x;
    int i;
    int j;
    base = s * WAYS;
    if (tree_mode) begin
      node = 0;
      for (j = TREE_LEVELS; j > 0; j--) begin
        idx = s * TREE_NODES + node;
        if ((w >> (j - 1)) & 1) begin
          tree_bits[idx] = 1'b0;
          node = node * 2 + 2;
        end else begin
          tree_bits[idx] = 1'b1;
          node = node * 2 + 1;
        end
      end
    end else begin
      for (x = 0; x < fill_cnt[s]; x++)
        if (recency[base + x] == w) break;
      // a way missing from the list goes to the front; a full list drops its last rank
      if (x >= WAYS) x = WAYS - 1;
      for (i = x; i > 0; i--) recency[base + i] = recency[base + i - 1];
      recency[base] = w;
    end
  endfunction

  // Pick a victim way and install the tag there
  function automatic void fill_way(int s, tag_t tag);
    int base;
    int num;
    int victim;
    int node;
    int path;
    int idx;
    int i;
    int j;
    base = s * WAYS;
    num  = fill_cnt[s];
    if (tree_mode) begin
      node = 0;
      path = 0;
      for (j = 0; j < TREE_LEVELS; j++) begin
        idx = s * TREE_NODES + node;
        if (tree_bits[idx]) begin
          tree_bits[idx] = 1'b0;
          node = node * 2 + 2;
          path = path * 2 + 1;
        end else begin
          tree_bits[idx] = 1'b1;
          node = node * 2 + 1;
          path = path * 2;
        end
      end
      victim = path;
    end else begin
      // empty ways fill in order, then the last rank is evicted
      victim = (num < WAYS) ? num : recency[base + WAYS - 1] % WAYS;
      for (i = (num < WAYS) ? num : WAYS - 1; i > 0; i--)
        recency[base + i] = recency[base + i - 1];
      recency[base] = victim;
    end
    line_tag[base + victim]   = tag;
    line_valid[base + victim] = 1'b1;
    if (num < WAYS) fill_cnt[s] = num + 1;
  endfunction

  // Look up one access, update the mirror and return the hit flag
  function automatic logic cache_lookup(logic [ADDR_W-1:0] a, logic rd);
    int   s;
    int   base;
    int   found;
    int   w;
    tag_t tag;
    s     = int'(a[OFFSET_BITS +: SET_BITS]);
    tag   = tag_t'(a >> (OFFSET_BITS + SET_BITS));
    base  = s * WAYS;
    found = -1;
    for (w = 0; w < WAYS; w++) begin
      if (line_valid[base + w] && line_tag[base + w] == tag) begin
        found = w;
        break;
      end
    end
    if (found >= 0) begin
      touch_way(s, found);
      return 1'b1;
    end
    if (rd || alloc_on_write) fill_way(s, tag);
    return 1'b0;
  endfunction

  function automatic logic [ADDR_W-1:0] make_addr(tag_t tag, int s, int off);
    return {tag, SET_BITS'(s), OFFSET_BITS'(off)};
  endfunction

  function automatic stim_row_t acc_row(tag_t tag, int s, int off, logic rd,
                                        bit known, logic exp_hit);
    stim_row_t r;
    r.kind    = ROW_ACCESS;
    r.addr    = make_addr(tag, s, off);
    r.rd      = rd;
    r.known   = known;
    r.hit     = exp_hit;
    r.reg_idx = '0;
    r.reg_val = '0;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] val);
    stim_row_t r;
    r.kind    = ROW_CONFIG;
    r.addr    = '0;
    r.rd      = 1'b0;
    r.known   = 1'b0;
    r.hit     = 1'b0;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // Issue one word after a random gap and record its expected hit flag
  task automatic send_word(logic [ADDR_W-1:0] a, logic rd, bit known, logic known_hit);
    int   gap;
    logic predicted;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else if ($urandom_range(0, 15) == 0) begin
      gap = 0;
      burst_left = $urandom_range(10, 30);
    end else begin
      gap = $urandom_range(0, 10);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    address <= a;
    is_read <= rd;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = cache_lookup(a, rd);
    pending_hits.push_back('{addr: a, hit: known ? known_hit : predicted});
  endtask

  // Drop start and wait until every word has returned and the block is idle
  task automatic settle();
    start <= 1'b0;
    @(negedge clk);
    while (pending_hits.size() != 0 || busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == CFG_USE_TREE_PLRU) tree_mode = val[0];
    else if (idx == CFG_WRITE_ALLOCATE) alloc_on_write = val[0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Check each result word against the oldest expectation
  always @(posedge clk) begin
    hit_expect_t exp_word;
    if (!rst && done) begin
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected result word, hit %0b", $time, hit);
        mismatch_count++;
      end else begin
        exp_word = pending_hits.pop_front();
        if (hit !== exp_word.hit) begin
          $display("%0t: hit mismatch for address %h, expected %0b, actual %0b",
                   $time, exp_word.addr, exp_word.hit, hit);
          mismatch_count++;
        end
      end
    end
  end

  // Guard against a hung block
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    stim_row_t         directed_rows[$];
    tag_t              hot_tags[HOT_TAGS];
    int                hot_sets[HOT_SETS];
    tag_t              ones;
    logic [ADDR_W-1:0] a;
    logic              rd;
    bit                pick_tree;
    bit                pick_alloc;
    int                p;
    int                n;
    int                k;

    ones = '1;
    // reset, address extremes, write allocation on and off
    directed_rows.push_back(acc_row('0, 0, 0, 1'b1, 1'b1, 1'b0));
    directed_rows.push_back(acc_row('0, 0, 63, 1'b1, 1'b1, 1'b1));
    directed_rows.push_back(acc_row(ones, NUM_SETS - 1, 63, 1'b1, 1'b1, 1'b0));
    directed_rows.push_back(acc_row(ones, NUM_SETS - 1, 0, 1'b0, 1'b1, 1'b1));
    directed_rows.push_back(acc_row(tag_t'(1), 0, 5, 1'b0, 1'b1, 1'b0));
    directed_rows.push_back(acc_row(tag_t'(1), 0, 9, 1'b1, 1'b1, 1'b1));
    directed_rows.push_back(cfg_row(CFG_WRITE_ALLOCATE, 1'b0));
    directed_rows.push_back(acc_row(tag_t'(2), 0, 0, 1'b0, 1'b1, 1'b0));
    directed_rows.push_back(acc_row(tag_t'(2), 0, 0, 1'b1, 1'b1, 1'b0));
    directed_rows.push_back(acc_row(tag_t'(3), 0, 0, 1'b1, 1'b1, 1'b0));
    directed_rows.push_back(acc_row('0, 0, 0, 1'b1, 1'b1, 1'b1));
    // full set under the recency list: evict the oldest way
    directed_rows.push_back(acc_row(tag_t'(4), 0, 0, 1'b1, 1'b1, 1'b0));
    directed_rows.push_back(acc_row(tag_t'(1), 0, 0, 1'b1, 1'b0, 1'b0));
    // tree policy: fill a fresh set, then walk the tree for a victim
    directed_rows.push_back(cfg_row(CFG_USE_TREE_PLRU, 1'b1));
    directed_rows.push_back(acc_row(tag_t'(5), 1, 0, 1'b1, 1'b1, 1'b0));
    directed_rows.push_back(acc_row(tag_t'(6), 1, 0, 1'b1, 1'b1, 1'b0));
    directed_rows.push_back(acc_row(tag_t'(7), 1, 0, 1'b1, 1'b1, 1'b0));
    directed_rows.push_back(acc_row(tag_t'(8), 1, 0, 1'b1, 1'b1, 1'b0));
    directed_rows.push_back(acc_row(tag_t'(9), 1, 0, 1'b1, 1'b0, 1'b0));
    directed_rows.push_back(acc_row(tag_t'(5), 1, 0, 1'b0, 1'b0, 1'b0));
    directed_rows.push_back(acc_row('0, 0, 0, 1'b1, 1'b0, 1'b0));
    // back to the list: hit ways the list never saw, then evict
    directed_rows.push_back(cfg_row(CFG_USE_TREE_PLRU, 1'b0));
    directed_rows.push_back(acc_row(tag_t'(7), 1, 0, 1'b1, 1'b0, 1'b0));
    directed_rows.push_back(acc_row(tag_t'(10), 1, 0, 1'b1, 1'b0, 1'b0));
    directed_rows.push_back(acc_row(tag_t'(6), 1, 0, 1'b0, 1'b0, 1'b0));
    directed_rows.push_back(cfg_row(CFG_WRITE_ALLOCATE, 1'b1));
    directed_rows.push_back(acc_row('0, NUM_SETS - 1, 0, 1'b0, 1'b1, 1'b0));

    // Hold reset, then set both registers while the clearing pass runs
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_reg(CFG_USE_TREE_PLRU, 1'b0);
    write_reg(CFG_WRITE_ALLOCATE, 1'b1);

    // Walk the directed table
    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_CONFIG) begin
        settle();
        write_reg(directed_rows[k].reg_idx, directed_rows[k].reg_val);
      end else begin
        send_word(directed_rows[k].addr, directed_rows[k].rd,
                  directed_rows[k].known, directed_rows[k].hit);
      end
    end

    // Hot sets include both ends of the index range
    hot_sets[0] = 0;
    hot_sets[1] = NUM_SETS - 1;
    for (k = 2; k < HOT_SETS; k++) hot_sets[k] = $urandom_range(0, NUM_SETS - 1);
    for (k = 0; k < HOT_TAGS; k++) hot_tags[k] = tag_t'({$urandom, $urandom});

    // Random phases: more tags than ways per set keeps evictions going
    for (p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: begin pick_tree = 1'b0; pick_alloc = 1'b1; end
        1: begin pick_tree = 1'b1; pick_alloc = 1'b1; end
        2: begin pick_tree = 1'b1; pick_alloc = 1'b0; end
        3: begin pick_tree = 1'b0; pick_alloc = 1'b0; end
        default: begin
          pick_tree  = 1'($urandom_range(0, 1));
          pick_alloc = 1'($urandom_range(0, 1));
        end
      endcase
      write_reg(CFG_USE_TREE_PLRU, pick_tree);
      write_reg(CFG_WRITE_ALLOCATE, pick_alloc);
      for (n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(0, 99) < 85)
          a = make_addr(hot_tags[$urandom_range(0, HOT_TAGS - 1)],
                        hot_sets[$urandom_range(0, HOT_SETS - 1)],
                        $urandom_range(0, (1 << OFFSET_BITS) - 1));
        else
          a = {$urandom, $urandom};
        rd = ($urandom_range(0, 99) < 60);
        send_word(a, rd, 1'b0, 1'b0);
      end
    end

    // Drain and let the block run out
    settle();
    repeat (MAX_LATENCY + 4) @(posedge clk);
    if (mismatch_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
